### sv/radar_camera_timestamp_matcher_core_defines.svh
// Assertion macros used by the timestamp matcher RTL.
`ifndef RADAR_CAMERA_TIMESTAMP_MATCHER_CORE_DEFINES_SVH
`define RADAR_CAMERA_TIMESTAMP_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RCTM_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rctm: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RCTM_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rctm: next-cycle check failed");

`endif

### sv/rctm_pkg.sv
// Shared types, widths and codes of the radar/camera timestamp matcher.
`default_nettype none

package rctm_pkg;

  localparam int BUFFER_DEPTH = 32;

  localparam int KIND_W    = 2;
  localparam int STAMP_W   = 40;
  localparam int CSTAMP_W  = STAMP_W + 1;
  localparam int SDIFF_W   = CSTAMP_W + 1;
  localparam int ABS_W     = CSTAMP_W;
  localparam int TAG_W     = 16;
  localparam int TOL_W     = 10;
  localparam int DELAY_W   = 12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_CAMERA = 2'd0;
  localparam kind_t KIND_RADAR  = 2'd1;
  localparam kind_t KIND_SYNC   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_DELAY    = 1'b1;

  localparam logic OUTCOME_MATCH = 1'b0;
  localparam logic OUTCOME_DROP  = 1'b1;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 10'd50;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 12'd600;

  typedef struct packed {
    kind_t               op;
    logic [CSTAMP_W-1:0] stamp;
    logic [TAG_W-1:0]    tag;
  } cmd_t;

endpackage

`default_nettype wire

### sv/rctm_in_if.sv
// Input channel carrying frame arrivals and sync ticks.
`default_nettype none

interface rctm_in_if;
  import rctm_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [STAMP_W-1:0] arrival_stamp;
  logic [TAG_W-1:0]   frame_tag;

  modport source (output valid, output kind, output arrival_stamp, output frame_tag,
                  input ready);
  modport sink (input valid, input kind, input arrival_stamp, input frame_tag,
                output ready);
endinterface

`default_nettype wire

### sv/rctm_out_if.sv
// Result channel carrying matched pairs and dropped radar frames.
`default_nettype none

interface rctm_out_if;
  import rctm_pkg::*;

  logic               valid;
  logic               ready;
  logic               outcome;
  logic [TAG_W-1:0]   radar_tag;
  logic [TAG_W-1:0]   camera_tag;
  logic [STAMP_W-1:0] pair_stamp;

  modport source (output valid, output outcome, output radar_tag, output camera_tag,
                  output pair_stamp, input ready);
  modport sink (input valid, input outcome, input radar_tag, input camera_tag,
                input pair_stamp, output ready);
endinterface

`default_nettype wire

### sv/rctm_cfg_if.sv
// Configuration write channel.
`default_nettype none

interface rctm_cfg_if;
  import rctm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/rctm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rctm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/rctm_front.sv
// Front end: configuration registers, input acceptance and command classification.
`default_nettype none

module rctm_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  rctm_in_if.sink                     in_if,
  rctm_cfg_if.sink                    cfg_if,
  output logic                        cmd_valid,
  input  wire logic                   cmd_ready,
  output rctm_pkg::cmd_t              cmd,
  output logic [rctm_pkg::TOL_W-1:0]  tolerance
);
  import rctm_pkg::*;

  logic [TOL_W-1:0]   tol_r;
  logic [TOL_W-1:0]   tol_nxt;
  logic [DELAY_W-1:0] delay_r;
  logic [DELAY_W-1:0] delay_nxt;

  assign cfg_if.ready = 1'b1;
  assign tolerance    = tol_r;

  always_comb begin
    tol_nxt   = tol_r;
    delay_nxt = delay_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_MATCH_TOLERANCE: tol_nxt = cfg_if.data[TOL_W-1:0];
        REG_CAMERA_DELAY:    delay_nxt = cfg_if.data[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= TOL_RESET;
      delay_r <= DELAY_RESET;
    end else begin
      tol_r   <= tol_nxt;
      delay_r <= delay_nxt;
    end
  end

  // Camera stamps are stored with the sensor delay already removed.
  always_comb begin
    cmd.op  = in_if.kind;
    cmd.tag = in_if.frame_tag;
    if (in_if.kind == KIND_CAMERA) begin
      cmd.stamp = {1'b0, in_if.arrival_stamp} - CSTAMP_W'(delay_r);
    end else begin
      cmd.stamp = {1'b0, in_if.arrival_stamp};
    end
  end

  assign cmd_valid   = in_if.valid && (in_if.kind inside {KIND_CAMERA, KIND_RADAR, KIND_SYNC});
  assign in_if.ready = cmd_ready;

endmodule

`default_nettype wire

### sv/rctm_cmd_q.sv
// Short command queue between the front end and the buffer engine.
`default_nettype none

module rctm_cmd_q (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           s_valid,
  output logic                s_ready,
  input  wire rctm_pkg::cmd_t s_data,
  output logic                m_valid,
  input  wire logic           m_ready,
  output rctm_pkg::cmd_t      m_data
);
  import rctm_pkg::*;

  cmd_t               slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;
  logic               push;
  logic               pop;

  assign s_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign m_valid = (cnt_r != '0);
  assign m_data  = slots_r[rd_ptr_r];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= s_data;
    end
  end

endmodule

`default_nettype wire

### sv/rctm_back.sv
// Buffer engine: radar and camera frame buffers, the matching scan and the result register.
`default_nettype none
`include "radar_camera_timestamp_matcher_core_defines.svh"

module rctm_back #(
  parameter int DEPTH = rctm_pkg::BUFFER_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire rctm_pkg::cmd_t              cmd,
  input  wire logic [rctm_pkg::TOL_W-1:0]  tolerance,
  rctm_out_if.source                       out_if
);
  import rctm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int RAD_W = STAMP_W + TAG_W;
  localparam int CAM_W = CSTAMP_W + TAG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  logic               state_r, state_nxt;
  logic [PTR_W-1:0]   rhead_r, rhead_nxt;
  logic [CNT_W-1:0]   rcount_r, rcount_nxt;
  logic [PTR_W-1:0]   chead_r, chead_nxt;
  logic [CNT_W-1:0]   ccount_r, ccount_nxt;
  logic [PTR_W-1:0]   caddr_r, caddr_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               v1_r, v1_nxt;
  logic [PTR_W-1:0]   idx1_r, idx1_nxt;
  logic               v2_r, v2_nxt;
  logic [PTR_W-1:0]   idx2_r, idx2_nxt;
  logic [ABS_W-1:0]   d_r, d_nxt;
  logic [TAG_W-1:0]   tag2_r, tag2_nxt;
  logic               first_r, first_nxt;
  logic [ABS_W-1:0]   prev_r, prev_nxt;
  logic [ABS_W-1:0]   min_r, min_nxt;
  logic [PTR_W-1:0]   best_r, best_nxt;
  logic [TAG_W-1:0]   btag_r, btag_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_outcome_r, out_outcome_nxt;
  logic [TAG_W-1:0]   out_rtag_r, out_rtag_nxt;
  logic [TAG_W-1:0]   out_ctag_r, out_ctag_nxt;
  logic [STAMP_W-1:0] out_stamp_r, out_stamp_nxt;

  logic               rad_we, rad_re, cam_we, cam_re;
  logic [PTR_W-1:0]   rad_waddr, rad_raddr, cam_waddr, cam_raddr;
  logic [RAD_W-1:0]   rad_rdata;
  logic [CAM_W-1:0]   cam_rdata;

  logic [STAMP_W-1:0]  rad_stamp;
  logic [TAG_W-1:0]    rad_tag;
  logic [CSTAMP_W-1:0] cam_stamp;
  logic [TAG_W-1:0]    cam_tag;
  logic [SDIFF_W-1:0]  diff_pos;
  logic [SDIFF_W-1:0]  diff_neg;
  logic [ABS_W-1:0]    diff_abs;
  logic                rise;
  logic                last;
  logic                drop;
  logic                match;
  logic                out_load;
  logic [CNT_W-1:0]    adv;

  rctm_ram #(.WIDTH(RAD_W), .DEPTH(DEPTH)) u_rad_ram (
    .clk   (clk),
    .we    (rad_we),
    .waddr (rad_waddr),
    .wdata ({cmd.stamp[STAMP_W-1:0], cmd.tag}),
    .re    (rad_re),
    .raddr (rad_raddr),
    .rdata (rad_rdata)
  );

  rctm_ram #(.WIDTH(CAM_W), .DEPTH(DEPTH)) u_cam_ram (
    .clk   (clk),
    .we    (cam_we),
    .waddr (cam_waddr),
    .wdata ({cmd.stamp, cmd.tag}),
    .re    (cam_re),
    .raddr (cam_raddr),
    .rdata (cam_rdata)
  );

  assign rad_stamp = rad_rdata[RAD_W-1:TAG_W];
  assign rad_tag   = rad_rdata[TAG_W-1:0];
  assign cam_stamp = cam_rdata[CAM_W-1:TAG_W];
  assign cam_tag   = cam_rdata[TAG_W-1:0];

  // Both directions are formed in parallel so that the absolute value is a select.
  assign diff_pos = {cam_stamp[CSTAMP_W-1], cam_stamp} - {2'b00, rad_stamp};
  assign diff_neg = {2'b00, rad_stamp} - {cam_stamp[CSTAMP_W-1], cam_stamp};
  assign diff_abs = diff_pos[SDIFF_W-1] ? diff_neg[ABS_W-1:0] : diff_pos[ABS_W-1:0];

  assign rise     = v2_r && !first_r && (d_r > prev_r);
  assign last     = v2_r && !rise && (CNT_W'(idx2_r) == ccount_r - CNT_W'(1));
  assign drop     = rise && (min_r > ABS_W'(tolerance));
  assign match    = rise && (min_r < ABS_W'(tolerance));
  assign out_load = drop || match;
  assign adv      = CNT_W'(best_r) + CNT_W'(1);

  always_comb begin
    state_nxt       = state_r;
    rhead_nxt       = rhead_r;
    rcount_nxt      = rcount_r;
    chead_nxt       = chead_r;
    ccount_nxt      = ccount_r;
    caddr_nxt       = caddr_r;
    iss_nxt         = iss_r;
    v1_nxt          = 1'b0;
    idx1_nxt        = idx1_r;
    v2_nxt          = 1'b0;
    idx2_nxt        = idx2_r;
    d_nxt           = d_r;
    tag2_nxt        = tag2_r;
    first_nxt       = first_r;
    prev_nxt        = prev_r;
    min_nxt         = min_r;
    best_nxt        = best_r;
    btag_nxt        = btag_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_outcome_nxt = out_outcome_r;
    out_rtag_nxt    = out_rtag_r;
    out_ctag_nxt    = out_ctag_r;
    out_stamp_nxt   = out_stamp_r;
    cmd_ready       = 1'b0;
    rad_we          = 1'b0;
    rad_re          = 1'b0;
    cam_we          = 1'b0;
    cam_re          = 1'b0;
    rad_waddr       = slot_of(rhead_r, rcount_r);
    cam_waddr       = slot_of(chead_r, ccount_r);
    rad_raddr       = rhead_r;
    cam_raddr       = caddr_r;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            KIND_CAMERA: begin
              cmd_ready = 1'b1;
              cam_we    = 1'b1;
              if (ccount_r == CNT_W'(DEPTH)) begin
                chead_nxt = slot_of(chead_r, CNT_W'(1));
              end else begin
                ccount_nxt = ccount_r + CNT_W'(1);
              end
            end
            KIND_RADAR: begin
              cmd_ready = 1'b1;
              rad_we    = 1'b1;
              if (rcount_r == CNT_W'(DEPTH)) begin
                rhead_nxt = slot_of(rhead_r, CNT_W'(1));
              end else begin
                rcount_nxt = rcount_r + CNT_W'(1);
              end
            end
            KIND_SYNC: begin
              if (!out_valid_r) begin
                cmd_ready = 1'b1;
                if ((rcount_r != '0) && (ccount_r != '0)) begin
                  rad_re    = 1'b1;
                  cam_re    = 1'b1;
                  cam_raddr = chead_r;
                  caddr_nxt = slot_of(chead_r, CNT_W'(1));
                  iss_nxt   = CNT_W'(1);
                  v1_nxt    = 1'b1;
                  idx1_nxt  = '0;
                  first_nxt = 1'b1;
                  state_nxt = ST_SCAN;
                end
              end
            end
            default: cmd_ready = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (iss_r < ccount_r) begin
          cam_re    = 1'b1;
          caddr_nxt = slot_of(caddr_r, CNT_W'(1));
          iss_nxt   = iss_r + CNT_W'(1);
          v1_nxt    = 1'b1;
          idx1_nxt  = iss_r[PTR_W-1:0];
        end
        v2_nxt   = v1_r;
        d_nxt    = diff_abs;
        idx2_nxt = idx1_r;
        tag2_nxt = cam_tag;
        if (rise) begin
          state_nxt = ST_IDLE;
          v1_nxt    = 1'b0;
          v2_nxt    = 1'b0;
          if (out_load) begin
            out_valid_nxt = 1'b1;
            out_rtag_nxt  = rad_tag;
            out_stamp_nxt = rad_stamp;
            rhead_nxt     = slot_of(rhead_r, CNT_W'(1));
            rcount_nxt    = rcount_r - CNT_W'(1);
          end
          if (drop) begin
            out_outcome_nxt = OUTCOME_DROP;
            out_ctag_nxt    = '0;
          end
          if (match) begin
            out_outcome_nxt = OUTCOME_MATCH;
            out_ctag_nxt    = btag_r;
            chead_nxt       = slot_of(chead_r, adv);
            ccount_nxt      = ccount_r - adv;
          end
        end else if (v2_r) begin
          if (first_r || (d_r < min_r)) begin
            min_nxt  = d_r;
            best_nxt = idx2_r;
            btag_nxt = tag2_r;
          end
          prev_nxt  = d_r;
          first_nxt = 1'b0;
          if (last) begin
            state_nxt = ST_IDLE;
            v1_nxt    = 1'b0;
            v2_nxt    = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rhead_r     <= '0;
      rcount_r    <= '0;
      chead_r     <= '0;
      ccount_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rhead_r     <= rhead_nxt;
      rcount_r    <= rcount_nxt;
      chead_r     <= chead_nxt;
      ccount_r    <= ccount_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    caddr_r       <= caddr_nxt;
    iss_r         <= iss_nxt;
    idx1_r        <= idx1_nxt;
    idx2_r        <= idx2_nxt;
    d_r           <= d_nxt;
    tag2_r        <= tag2_nxt;
    first_r       <= first_nxt;
    prev_r        <= prev_nxt;
    min_r         <= min_nxt;
    best_r        <= best_nxt;
    btag_r        <= btag_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_rtag_r    <= out_rtag_nxt;
    out_ctag_r    <= out_ctag_nxt;
    out_stamp_r   <= out_stamp_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.outcome    = out_outcome_r;
  assign out_if.radar_tag  = out_rtag_r;
  assign out_if.camera_tag = out_ctag_r;
  assign out_if.pair_stamp = out_stamp_r;

  `RCTM_ASSERT_IMP(a_scan_needs_entries, state_r == ST_SCAN, (rcount_r != '0) && (ccount_r != '0))
  `RCTM_ASSERT_IMP(a_scan_slot_free, state_r == ST_SCAN, !out_valid_r)
  `RCTM_ASSERT_NXT(a_result_pops_radar, out_load, rcount_r == $past(rcount_r) - CNT_W'(1))
  `RCTM_ASSERT_IMP(a_drop_has_no_camera, out_valid_r && (out_outcome_r == OUTCOME_DROP), out_ctag_r == '0)
  `RCTM_ASSERT_IMP(a_stage_index_in_range, v2_r, CNT_W'(idx2_r) < ccount_r)

endmodule

`default_nettype wire

### sv/radar_camera_timestamp_matcher_core.sv
// Top level of the radar/camera timestamp matcher.
//
//   Channel  Direction  Carries
//   in_if    sink       kind, arrival_stamp, frame_tag
//   out_if   source     outcome, radar_tag, camera_tag, pair_stamp
//   cfg_if   sink       index, data (match_tolerance, camera_delay)
//
// The buffer engine writes a frame arrival into its buffer as it takes it from the queue.
// A sync tick with both buffers holding entries starts a scan of the camera buffer, read
// from its RAM one entry per cycle and compared with the oldest radar frame; the scan ends
// once the distance rises or the entries run out. Other sync ticks leave the buffers as they are.
// A sync tick waits in the queue while an earlier result has not been transferred; one
// further item is still taken meanwhile. Reset is synchronous and needs no clearing pass.
`default_nettype none

module radar_camera_timestamp_matcher_core #(
  parameter int BUFFER_DEPTH = rctm_pkg::BUFFER_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rctm_in_if.sink    in_if,
  rctm_out_if.source out_if,
  rctm_cfg_if.sink   cfg_if
);
  import rctm_pkg::*;

  logic             f_valid;
  logic             f_ready;
  cmd_t             f_cmd;
  logic             b_valid;
  logic             b_ready;
  cmd_t             b_cmd;
  logic [TOL_W-1:0] tolerance;

  rctm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_if    (cfg_if),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd),
    .tolerance (tolerance)
  );

  rctm_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_data  (f_cmd),
    .m_valid (b_valid),
    .m_ready (b_ready),
    .m_data  (b_cmd)
  );

  rctm_back #(.DEPTH(BUFFER_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .tolerance (tolerance),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

### sim/timestamp_match_checker.sv
// Checker for the timestamp matcher: watches all channels, predicts each result and compares it.
`timescale 1ns / 1ps

module timestamp_match_checker (
  input  logic clk,
  input  logic rst_n,
  rctm_in_if   in_ch,
  rctm_out_if  out_ch,
  rctm_cfg_if  cfg_ch,
  output int   mismatch_total,
  output int   open_expectations
);
  import rctm_pkg::*;

  typedef struct packed {
    logic               outcome;
    logic [TAG_W-1:0]   radar_tag;
    logic [TAG_W-1:0]   camera_tag;
    logic [STAMP_W-1:0] pair_stamp;
  } pair_result_t;

  localparam longint NO_GAP = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic [TOL_W-1:0]   tolerance_ms;
  logic [DELAY_W-1:0] delay_ms;

  logic [STAMP_W-1:0] radar_stamp_mem [BUFFER_DEPTH];
  logic [TAG_W-1:0]   radar_tag_mem [BUFFER_DEPTH];
  longint             camera_stamp_mem [BUFFER_DEPTH];
  logic [TAG_W-1:0]   camera_tag_mem [BUFFER_DEPTH];
  int                 radar_first;
  int                 radar_fill;
  int                 camera_first;
  int                 camera_fill;

  pair_result_t expected_pairs[$];
  int           failures = 0;

  task automatic predict_frame_event(input kind_t op, input logic [STAMP_W-1:0] stamp,
                                     input logic [TAG_W-1:0] tag);
    longint       head_ms;
    longint       gap;
    longint       best_gap;
    longint       last_gap;
    int           best_pos;
    int           slot;
    bit           stopped;
    pair_result_t res;
    case (op)
      KIND_CAMERA: begin
        if (camera_fill == BUFFER_DEPTH) begin
          camera_first = (camera_first + 1) % BUFFER_DEPTH;
          camera_fill--;
        end
        slot = (camera_first + camera_fill) % BUFFER_DEPTH;
        camera_stamp_mem[slot] = longint'(stamp) - longint'(delay_ms);
        camera_tag_mem[slot] = tag;
        camera_fill++;
      end
      KIND_RADAR: begin
        if (radar_fill == BUFFER_DEPTH) begin
          radar_first = (radar_first + 1) % BUFFER_DEPTH;
          radar_fill--;
        end
        slot = (radar_first + radar_fill) % BUFFER_DEPTH;
        radar_stamp_mem[slot] = stamp;
        radar_tag_mem[slot] = tag;
        radar_fill++;
      end
      KIND_SYNC: begin
        if (radar_fill != 0 && camera_fill != 0) begin
          head_ms = longint'(radar_stamp_mem[radar_first]);
          best_gap = NO_GAP;
          last_gap = NO_GAP;
          best_pos = 0;
          stopped = 1'b0;
          for (int i = 0; i < camera_fill && !stopped; i++) begin
            gap = camera_stamp_mem[(camera_first + i) % BUFFER_DEPTH] - head_ms;
            if (gap < 0) gap = -gap;
            if (gap > last_gap) begin
              stopped = 1'b1;
            end else begin
              if (gap < best_gap) begin
                best_gap = gap;
                best_pos = i;
              end
              last_gap = gap;
            end
          end
          // A minimum exactly at the tolerance leaves both buffers untouched.
          if (stopped && best_gap != longint'(tolerance_ms)) begin
            res.radar_tag = radar_tag_mem[radar_first];
            res.pair_stamp = radar_stamp_mem[radar_first];
            if (best_gap > longint'(tolerance_ms)) begin
              res.outcome = OUTCOME_DROP;
              res.camera_tag = '0;
            end else begin
              camera_first = (camera_first + best_pos) % BUFFER_DEPTH;
              camera_fill -= best_pos;
              res.outcome = OUTCOME_MATCH;
              res.camera_tag = camera_tag_mem[camera_first];
              camera_first = (camera_first + 1) % BUFFER_DEPTH;
              camera_fill--;
            end
            radar_first = (radar_first + 1) % BUFFER_DEPTH;
            radar_fill--;
            expected_pairs.insert(expected_pairs.size(), res);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pair_result_t want;
    if (!rst_n) begin
      tolerance_ms = TOL_RESET;
      delay_ms = DELAY_RESET;
      radar_first = 0;
      radar_fill = 0;
      camera_first = 0;
      camera_fill = 0;
      expected_pairs.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_MATCH_TOLERANCE) tolerance_ms = cfg_ch.data[TOL_W-1:0];
        else if (cfg_ch.index == REG_CAMERA_DELAY) delay_ms = cfg_ch.data[DELAY_W-1:0];
      end
      if (in_ch.valid && in_ch.ready)
        predict_frame_event(in_ch.kind, in_ch.arrival_stamp, in_ch.frame_tag);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pairs.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected result: outcome %0d radar_tag %h camera_tag %h stamp %h",
                     $realtime, out_ch.outcome, out_ch.radar_tag, out_ch.camera_tag,
                     out_ch.pair_stamp);
        end else begin
          want = expected_pairs[0];
          expected_pairs.delete(0);
          if (want.outcome !== out_ch.outcome || want.radar_tag !== out_ch.radar_tag ||
              want.camera_tag !== out_ch.camera_tag || want.pair_stamp !== out_ch.pair_stamp)
          begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch: expected %0d %h %h %h, got %0d %h %h %h",
                       $realtime, want.outcome, want.radar_tag, want.camera_tag,
                       want.pair_stamp, out_ch.outcome, out_ch.radar_tag, out_ch.camera_tag,
                       out_ch.pair_stamp);
          end
        end
      end
    end
    mismatch_total <= failures;
    open_expectations <= expected_pairs.size();
  end

endmodule

### sim/radar_camera_timestamp_matcher_core_test.sv
// Testbench top for the timestamp matcher: stimulus, flow control and the final verdict.
`timescale 1ns / 1ps

module radar_camera_timestamp_matcher_core_test;
  import rctm_pkg::*;

  localparam kind_t KIND_UNUSED   = 2'd3;
  localparam int    SETTLE_CYCLES = 150;
  localparam int    CYCLE_LIMIT   = 1000000;
  localparam int    PHASE_ITEMS   = 200;

  logic clk = 1'b0;
  logic rst_n;

  rctm_in_if  frame_ch ();
  rctm_out_if result_ch ();
  rctm_cfg_if cfg_ch ();

  int mismatch_total;
  int open_expectations;

  radar_camera_timestamp_matcher_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (frame_ch),
    .out_if (result_ch),
    .cfg_if (cfg_ch)
  );

  timestamp_match_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (frame_ch),
    .out_ch            (result_ch),
    .cfg_ch            (cfg_ch),
    .mismatch_total    (mismatch_total),
    .open_expectations (open_expectations)
  );

  always #4 clk = ~clk;

  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls at the start of each window of random length, in some windows not at all.
  int stall_phase = 0;
  int stall_period = 0;
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (stall_phase >= stall_period) begin
      stall_phase = 0;
      stall_period = $urandom_range(1, 32);
      stall_cycles = ($urandom_range(0, 3) == 0) ? 0 :
                     $urandom_range(0, (stall_period < 24) ? stall_period - 1 : 23);
    end
    result_ch.ready <= rst_n && (stall_phase >= stall_cycles);
    stall_phase++;
  end

  logic [STAMP_W-1:0] now_ms;
  logic [DELAY_W-1:0] delay_now = DELAY_RESET;
  int                 counted_items = 0;
  int                 burst_left = 1;

  function automatic logic [STAMP_W-1:0] random_stamp();
    logic [63:0] word;
    word = {$urandom(), $urandom()};
    return word[STAMP_W-1:0];
  endfunction

  task automatic send_event(input kind_t op, input logic [STAMP_W-1:0] stamp,
                            input logic [TAG_W-1:0] tag);
    int gap;
    frame_ch.valid <= 1'b1;
    frame_ch.kind <= op;
    frame_ch.arrival_stamp <= stamp;
    frame_ch.frame_tag <= tag;
    do @(posedge clk); while (!frame_ch.ready);
    if (op != KIND_UNUSED) counted_items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        frame_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    frame_ch.valid <= 1'b0;
    do @(posedge clk); while (open_expectations != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] tol_word,
                           input logic [CFG_DATA_W-1:0] delay_word);
    int                 target;
    int                 ncam;
    int                 offset;
    longint             arrival;
    logic [STAMP_W-1:0] radar_ms;
    kind_t              flood_kind;
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_MATCH_TOLERANCE;
    cfg_ch.data <= tol_word;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_CAMERA_DELAY;
    cfg_ch.data <= delay_word;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    delay_now = delay_word;
    now_ms = random_stamp() >> $urandom_range(0, 24);
    target = counted_items + PHASE_ITEMS;
    while (counted_items < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          flood_kind = ($urandom_range(0, 1) == 0) ? KIND_CAMERA : KIND_RADAR;
          repeat ($urandom_range(20, 40))
            send_event(flood_kind, now_ms + $urandom_range(0, 2000), 16'($urandom));
          send_event(KIND_SYNC, random_stamp(), 16'($urandom));
        end
        3, 4, 5:
          send_event(kind_t'($urandom_range(0, 3)), random_stamp(), 16'($urandom));
        default: begin
          // A radar frame followed by camera frames that close in on it and may then pass it.
          radar_ms = now_ms;
          send_event(KIND_RADAR, radar_ms, 16'($urandom));
          ncam = $urandom_range(1, 6);
          offset = 0 - int'($urandom_range(0, 400));
          for (int i = 0; i < ncam; i++) begin
            arrival = longint'(radar_ms) + longint'(delay_now) + longint'(offset);
            send_event(KIND_CAMERA, arrival[STAMP_W-1:0], 16'($urandom));
            offset += $urandom_range(1, 150);
            if ($urandom_range(0, 7) == 0)
              send_event(KIND_RADAR, radar_ms + $urandom_range(1, 300), 16'($urandom));
          end
          repeat ($urandom_range(1, 2)) send_event(KIND_SYNC, random_stamp(), 16'($urandom));
          now_ms += $urandom_range(100, 500);
        end
      endcase
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    frame_ch.valid <= 1'b0;
    frame_ch.kind <= KIND_CAMERA;
    frame_ch.arrival_stamp <= '0;
    frame_ch.frame_tag <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_MATCH_TOLERANCE;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings apply here: tolerance 50 ms, camera delay 600 ms.
    send_event(KIND_SYNC, random_stamp(), 16'($urandom));
    send_event(KIND_UNUSED, random_stamp(), 16'($urandom));
    send_event(KIND_RADAR, 40'd0, 16'h0000);
    send_event(KIND_SYNC, 40'd0, 16'h0000);
    send_event(KIND_CAMERA, 40'd0, 16'hFFFF);
    send_event(KIND_SYNC, 40'd0, 16'h0000);
    send_event(KIND_CAMERA, 40'd100, 16'h0001);
    send_event(KIND_CAMERA, 40'd2000, 16'h0002);
    send_event(KIND_SYNC, 40'd0, 16'h0000);
    // Two camera frames lie equally close to this radar frame; the older one must win.
    send_event(KIND_RADAR, 40'd1420, 16'h5A5A);
    send_event(KIND_CAMERA, 40'd2040, 16'h00C3);
    send_event(KIND_CAMERA, 40'd2100, 16'h0004);
    send_event(KIND_SYNC, random_stamp(), 16'($urandom));
    send_event(KIND_RADAR, 40'd1390, 16'h1111);
    send_event(KIND_SYNC, 40'd0, 16'h0000);
    send_event(KIND_SYNC, {STAMP_W{1'b1}}, 16'hFFFF);
    send_event(KIND_RADAR, {STAMP_W{1'b1}}, 16'hFFFF);
    send_event(KIND_CAMERA, {STAMP_W{1'b1}}, 16'h0000);

    run_phase(12'd0, 12'd0);
    run_phase(12'hFFF, 12'd4095);
    run_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    run_phase(12'd200, 12'd600);
    run_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    run_phase(12'd50, 12'd600);
    drain_results();

    if (mismatch_total == 0 && open_expectations == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/rctm_pkg.sv
sv/rctm_in_if.sv
sv/rctm_out_if.sv
sv/rctm_cfg_if.sv
sv/rctm_ram.sv
sv/rctm_front.sv
sv/rctm_cmd_q.sv
sv/rctm_back.sv
sv/radar_camera_timestamp_matcher_core.sv
sim/timestamp_match_checker.sv
sim/radar_camera_timestamp_matcher_core_test.sv
